/* design/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Opcodes, task modes, status codes and the controller command struct.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TaskSlots = 16;
    localparam int SemNum    = 8;
    localparam int PrioBits  = 8;
    localparam int SlotW     = $clog2(TaskSlots);
    localparam int CntW      = $clog2(TaskSlots + 1);
    localparam int SemW      = $clog2(SemNum);

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0, OP_EXIT = 3'd1, OP_DELAY = 3'd2, OP_YIELD = 3'd3,
        OP_TICK = 3'd4, OP_TAKE = 3'd5, OP_GIVE = 3'd6, OP_INIT = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        MODE_FREE = 3'd0, MODE_RUN = 3'd1, MODE_READY = 3'd2, MODE_SLEEP = 3'd3,
        MODE_SEM_TIMED = 3'd4, MODE_SEM_FOREVER = 3'd5
    } t_mode;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_UNAVAIL = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_WAKE, S_DISPATCH, S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic exec;      // perform the opcode's main step
        logic wake;      // wake one expired sleeper
        logic dispatch;  // run the dispatch step
        logic publish;   // latch the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wake_more;   // head sleeper is due
        logic need_disp;   // a dispatch is pending
    } t_stat;

endpackage

/* design/priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_task_scheduler: preemptive priority task scheduler
// Top level joining the sequencing controller and the scheduler datapath.
// ----------------------------------------------------------------------------
// Usage: an item (opcode with its operands) enters on the i_valid/o_ready
// channel and yields exactly one result on o_valid/i_ready.
// Lower priority numbers win; equal priorities are served first in, first out.
// A tick also runs a wake-up loop that wakes one sleeper per cycle, at most
// 15 of them; every other item goes from execute straight to dispatch.
// One item is in work at a time. The result sits in an output register, so
// the next item may be accepted while a result still waits to be taken; a
// second result waits in the controller until the register frees.
// Reset (synchronous, active low) frees every task, empties both lists,
// clears semaphores and the tick count. No clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_task_scheduler
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_task_slot,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_wait_ticks,
    input  logic        i_wait_forever,
    input  logic [2:0]  i_sem_index,
    input  logic [15:0] i_sem_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_running_task,
    output logic        o_switched,
    output logic [1:0]  o_status,
    output logic [4:0]  o_woken_count,
    output logic        o_resume_timed_out,
    output logic [31:0] o_tick_now
);

    t_cmd  cmd;
    t_stat stat;
    t_op   op;
    logic  out_full;

    pts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .i_out_full(out_full), .i_op(op),
        .i_stat(stat), .o_cmd(cmd)
    );

    pts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat), .o_op(op),
        .i_opcode(i_opcode), .i_task_slot(i_task_slot),
        .i_priority_req(i_priority_req), .i_wait_ticks(i_wait_ticks),
        .i_wait_forever(i_wait_forever), .i_sem_index(i_sem_index),
        .i_sem_start(i_sem_start), .i_out_ready(i_ready), .o_out_full(out_full),
        .o_valid(o_valid), .o_running_task(o_running_task),
        .o_switched(o_switched), .o_status(o_status),
        .o_woken_count(o_woken_count), .o_resume_timed_out(o_resume_timed_out),
        .o_tick_now(o_tick_now)
    );

endmodule

/* design/pts_ctrl.sv */
// ----------------------------------------------------------------------------
// pts_ctrl: sequencing controller
// Steps one item through execute, wake-up loop (tick only), dispatch, result.
// ----------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_out_ready,
    input  logic  i_out_full,
    input  t_op   i_op,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_EXEC;
            S_EXEC:     n_state = (i_op == OP_TICK) ? S_WAKE : S_DISPATCH;
            S_WAKE:     if (!i_stat.wake_more) n_state = S_DISPATCH;
            S_DISPATCH: n_state = S_OUT;
            S_OUT:      if (!i_out_full || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE:     begin o_ready = 1'b1; o_cmd.load = i_valid; end
            S_EXEC:     o_cmd.exec = 1'b1;
            S_WAKE:     o_cmd.wake = i_stat.wake_more;
            S_DISPATCH: o_cmd.dispatch = i_stat.need_disp;
            S_OUT:      o_cmd.publish = !i_out_full || i_out_ready;
            default:    o_cmd = '0;
        endcase
    end

endmodule

/* design/pts_dp.sv */
// ----------------------------------------------------------------------------
// pts_dp: scheduler datapath
// Task table, ordered ready and sleep lists, semaphores and the result register.
// ----------------------------------------------------------------------------
module pts_dp
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_op         o_op,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_task_slot,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_wait_ticks,
    input  logic        i_wait_forever,
    input  logic [2:0]  i_sem_index,
    input  logic [15:0] i_sem_start,
    input  logic        i_out_ready,
    output logic        o_out_full,
    output logic        o_valid,
    output logic [3:0]  o_running_task,
    output logic        o_switched,
    output logic [1:0]  o_status,
    output logic [4:0]  o_woken_count,
    output logic        o_resume_timed_out,
    output logic [31:0] o_tick_now
);

    // Captured item.
    t_op                 r_op;
    logic [SlotW-1:0]    r_slot;
    logic [PrioBits-1:0] r_prio;
    logic [31:0]         r_ticks;
    logic                r_forever;
    logic [SemW-1:0]     r_si;
    logic [15:0]         r_start;

    // Scheduler state.
    logic [PrioBits-1:0] r_tprio [TaskSlots];
    t_mode               r_mode  [TaskSlots];
    logic [31:0]         r_dl    [TaskSlots];
    logic                r_wc    [TaskSlots];
    logic [SlotW-1:0]    r_rdy   [TaskSlots];
    logic [SlotW-1:0]    r_slp   [TaskSlots];
    logic [CntW-1:0]     r_rcnt, r_scnt;
    logic                r_cv;
    logic [SlotW-1:0]    r_cur;
    logic [31:0]         r_tick;
    logic [15:0]         r_sc    [SemNum];
    logic                r_wv    [SemNum];
    logic [SlotW-1:0]    r_sw    [SemNum];

    // Per-item scratch.
    logic       r_ocv;
    logic [SlotW-1:0] r_ocur;
    logic [1:0] r_st;
    logic [CntW-1:0] r_woken;
    logic       r_disp;

    // Result register.
    logic        r_ov;
    logic [3:0]  r_orun;
    logic        r_osw;
    logic [1:0]  r_ost;
    logic [4:0]  r_owk;
    logic        r_oto;
    logic [31:0] r_otick;

    logic sem_ok;
    logic head_due;
    logic cur_run;
    assign sem_ok   = 1'b1;
    assign head_due = (r_scnt != '0) && !(r_tick < r_dl[r_slp[0]]);
    assign cur_run  = r_cv && (r_mode[r_cur] == MODE_RUN);

    assign o_stat.wake_more = head_due;
    assign o_stat.need_disp = r_disp && (r_rcnt != '0);
    assign o_op = r_op;
    assign o_out_full = r_ov;

    // Ordered insert of one task into a list (one shift stage in parallel).
    function automatic void ins_pos(
        input logic [SlotW-1:0] ord [TaskSlots], input logic [CntW-1:0] cnt,
        input logic [TaskSlots-1:0] after, input logic [SlotW-1:0] t,
        output logic [SlotW-1:0] res [TaskSlots]);
        for (int i = 0; i < TaskSlots; i++) begin
            if (i == 0) res[i] = after[0] ? ord[0] : t;
            else if (after[i]) res[i] = ord[i];
            else if (after[i-1]) res[i] = t;
            else res[i] = ord[i-1];
            if (i > int'(cnt)) res[i] = ord[i];
        end
    endfunction

    // Ready-list insert and removal helpers on the combinational copies.
    logic [SlotW-1:0] c_rdy [TaskSlots];
    logic [CntW-1:0]  c_rcnt;

    function automatic logic [TaskSlots-1:0] rdy_after(
        input logic [SlotW-1:0] ord [TaskSlots], input logic [CntW-1:0] cnt,
        input logic [PrioBits-1:0] p, input logic [PrioBits-1:0] pr [TaskSlots]);
        logic [TaskSlots-1:0] a;
        for (int i = 0; i < TaskSlots; i++)
            a[i] = (i < int'(cnt)) && !(p < pr[ord[i]]);
        return a;
    endfunction

    function automatic logic [TaskSlots-1:0] slp_after(
        input logic [SlotW-1:0] ord [TaskSlots], input logic [CntW-1:0] cnt,
        input logic [31:0] d, input logic [31:0] dl [TaskSlots]);
        logic [TaskSlots-1:0] a;
        for (int i = 0; i < TaskSlots; i++)
            a[i] = (i < int'(cnt)) && !(d < dl[ord[i]]);
        return a;
    endfunction

    logic [SlotW-1:0] t_ins [TaskSlots];
    logic [31:0]      new_dl;
    assign new_dl = r_tick + r_ticks;

    logic [CntW-1:0] c_pos;
    logic            c_hit;

    // Main sequential datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TaskSlots; i++) begin
                r_mode[i] <= MODE_FREE;
                r_dl[i]   <= '0;
                r_wc[i]   <= 1'b0;
            end
            for (int k = 0; k < SemNum; k++) begin
                r_sc[k] <= '0;
                r_wv[k] <= 1'b0;
            end
            r_rcnt <= '0; r_scnt <= '0; r_cv <= 1'b0; r_cur <= '0;
            r_tick <= '0; r_ov <= 1'b0; r_disp <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            // Item capture.
            if (i_cmd.load) begin
                r_op <= t_op'(i_opcode); r_slot <= i_task_slot;
                r_prio <= i_priority_req[PrioBits-1:0]; r_ticks <= i_wait_ticks;
                r_forever <= i_wait_forever; r_si <= i_sem_index;
                r_start <= i_sem_start;
                r_ocv <= r_cv; r_ocur <= r_cur; r_st <= ST_DONE;
                r_woken <= '0; r_disp <= 1'b0;
            end
            // Opcode execution.
            if (i_cmd.exec) begin
                case (r_op)
                    OP_CREATE: begin
                        if (r_mode[r_slot] != MODE_FREE) r_st <= ST_REJECT;
                        else begin
                            r_tprio[r_slot] <= r_prio; r_dl[r_slot] <= '0;
                            r_wc[r_slot] <= 1'b0;
                            if (!r_cv) begin
                                r_mode[r_slot] <= MODE_RUN; r_cur <= r_slot;
                                r_cv <= 1'b1;
                            end else begin
                                r_mode[r_slot] <= MODE_READY;
                                ins_pos(r_rdy, r_rcnt,
                                    rdy_after(r_rdy, r_rcnt, r_prio, r_tprio),
                                    r_slot, t_ins);
                                r_rdy <= t_ins; r_rcnt <= r_rcnt + 1'b1;
                                r_disp <= 1'b1;
                            end
                        end
                    end
                    OP_EXIT: begin
                        if (!r_cv || r_rcnt == '0) r_st <= ST_REJECT;
                        else begin
                            r_mode[r_cur] <= MODE_FREE;
                            r_disp <= 1'b1;
                        end
                    end
                    OP_DELAY: begin
                        if (!r_cv || r_rcnt == '0) r_st <= ST_REJECT;
                        else begin
                            r_mode[r_cur] <= MODE_SLEEP; r_dl[r_cur] <= new_dl;
                            ins_pos(r_slp, r_scnt,
                                slp_after(r_slp, r_scnt, new_dl, r_dl), r_cur, t_ins);
                            r_slp <= t_ins; r_scnt <= r_scnt + 1'b1;
                            r_disp <= 1'b1; r_st <= ST_BLOCKED;
                        end
                    end
                    OP_YIELD: begin
                        if (!r_cv) r_st <= ST_REJECT;
                        else r_disp <= 1'b1;
                    end
                    OP_TICK: r_tick <= r_tick + 32'd1;
                    OP_TAKE: begin
                        if (!sem_ok) r_st <= ST_REJECT;
                        else if (r_sc[r_si] != '0) r_sc[r_si] <= r_sc[r_si] - 16'd1;
                        else if (!r_forever && r_ticks == '0) r_st <= ST_UNAVAIL;
                        else if (!r_cv || r_rcnt == '0 || r_wv[r_si]) r_st <= ST_REJECT;
                        else begin
                            r_wv[r_si] <= 1'b1; r_sw[r_si] <= r_cur;
                            if (r_forever) begin
                                r_mode[r_cur] <= MODE_SEM_FOREVER;
                                r_dl[r_cur] <= '0; r_wc[r_cur] <= 1'b0;
                            end else begin
                                r_mode[r_cur] <= MODE_SEM_TIMED;
                                r_dl[r_cur] <= new_dl; r_wc[r_cur] <= 1'b1;
                                ins_pos(r_slp, r_scnt,
                                    slp_after(r_slp, r_scnt, new_dl, r_dl),
                                    r_cur, t_ins);
                                r_slp <= t_ins; r_scnt <= r_scnt + 1'b1;
                            end
                            r_disp <= 1'b1; r_st <= ST_BLOCKED;
                        end
                    end
                    OP_GIVE: begin
                        if (r_wv[r_si]) begin
                            r_wv[r_si] <= 1'b0; r_wc[r_sw[r_si]] <= 1'b0;
                            if (r_mode[r_sw[r_si]] == MODE_SEM_TIMED) begin
                                for (int i = 0; i < TaskSlots - 1; i++)
                                    if (i >= int'(c_pos) && i + 1 < int'(r_scnt))
                                        r_slp[i] <= r_slp[i+1];
                                if (c_hit) r_scnt <= r_scnt - 1'b1;
                            end
                            r_dl[r_sw[r_si]] <= '0;
                            r_mode[r_sw[r_si]] <= MODE_READY;
                            ins_pos(r_rdy, r_rcnt,
                                rdy_after(r_rdy, r_rcnt, r_tprio[r_sw[r_si]], r_tprio),
                                r_sw[r_si], t_ins);
                            r_rdy <= t_ins; r_rcnt <= r_rcnt + 1'b1;
                            r_disp <= 1'b1;
                        end else if (r_sc[r_si] != 16'hFFFF) begin
                            r_sc[r_si] <= r_sc[r_si] + 16'd1;
                        end
                    end
                    OP_INIT: begin
                        if (r_wv[r_si]) r_st <= ST_REJECT;
                        else r_sc[r_si] <= r_start;
                    end
                    default: r_st <= ST_REJECT;
                endcase
            end
            // One sleeper woken per cycle.
            if (i_cmd.wake) begin
                for (int i = 0; i < TaskSlots - 1; i++) r_slp[i] <= r_slp[i+1];
                r_scnt <= r_scnt - 1'b1;
                r_dl[r_slp[0]] <= '0;
                if (r_mode[r_slp[0]] == MODE_SEM_TIMED) begin
                    r_wc[r_slp[0]] <= 1'b1;
                    for (int k = 0; k < SemNum; k++)
                        if (r_wv[k] && r_sw[k] == r_slp[0]) r_wv[k] <= 1'b0;
                end
                r_mode[r_slp[0]] <= MODE_READY;
                ins_pos(r_rdy, r_rcnt,
                    rdy_after(r_rdy, r_rcnt, r_tprio[r_slp[0]], r_tprio),
                    r_slp[0], t_ins);
                r_rdy <= t_ins; r_rcnt <= r_rcnt + 1'b1;
                r_woken <= r_woken + 1'b1; r_disp <= 1'b1;
            end
            // Dispatch: a running task that outranks the head keeps the processor,
            // otherwise requeue it and run the head.
            if (i_cmd.dispatch) begin
                if (cur_run && r_tprio[r_cur] < r_tprio[r_rdy[0]]) begin
                    r_disp <= 1'b0;
                end else begin
                    for (int i = 0; i < TaskSlots; i++) r_rdy[i] <= c_rdy[i];
                    r_rcnt <= c_rcnt;
                    if (cur_run) r_mode[r_cur] <= MODE_READY;
                    r_mode[r_rdy[0]] <= MODE_RUN;
                    r_cur <= r_rdy[0]; r_cv <= 1'b1;
                end
            end
            // Result register.
            if (i_cmd.publish) begin
                r_ov <= 1'b1;
                r_orun <= r_cv ? 4'(r_cur) : 4'd0;
                r_osw <= (r_cv != r_ocv) || (r_cv && r_cur != r_ocur);
                r_ost <= r_st;
                r_owk <= 5'(r_woken);
                r_oto <= r_cv ? r_wc[r_cur] : 1'b0;
                r_otick <= r_tick;
            end
        end
    end

    // Position of the given waiter in the sleep list (for give).
    always_comb begin
        c_pos = CntW'(TaskSlots);
        c_hit = 1'b0;
        for (int i = TaskSlots - 1; i >= 0; i--)
            if (i < int'(r_scnt) && r_slp[i] == r_sw[r_si]) begin
                c_pos = CntW'(i); c_hit = 1'b1;
            end
    end

    // Ready list after dropping the head and requeueing a running caller.
    logic [SlotW-1:0]     c_pop [TaskSlots];
    logic [TaskSlots-1:0] c_aft;
    always_comb begin
        for (int i = 0; i < TaskSlots; i++) begin
            c_pop[i] = (i + 1 < TaskSlots) ? r_rdy[i+1] : r_rdy[i];
        end
        c_rcnt = r_rcnt - 1'b1;
        c_aft = rdy_after(c_pop, c_rcnt, r_tprio[r_cur], r_tprio);
        if (cur_run) begin
            ins_pos(c_pop, c_rcnt, c_aft, r_cur, c_rdy);
            c_rcnt = r_rcnt;
        end else begin
            for (int i = 0; i < TaskSlots; i++) c_rdy[i] = c_pop[i];
        end
    end

    assign o_valid            = r_ov;
    assign o_running_task     = r_orun;
    assign o_switched         = r_osw;
    assign o_status           = r_ost;
    assign o_woken_count      = r_owk;
    assign o_resume_timed_out = r_oto;
    assign o_tick_now         = r_otick;

endmodule
